// ===== design/ntc_pkg.sv =====
package ntc_pkg;

  localparam int ADC_BITS_DEF = 12;
  localparam int MV_FULL      = 5000;
  localparam int MV_W         = 13;
  localparam int DIVIDEND_R   = 500000000;
  localparam int RES_OFS      = 100000;
  localparam int DIV_W        = 29;
  localparam int DIV_CNT_W    = $clog2(DIV_W);
  localparam int ENT_W        = 21;
  localparam int IDX_W        = 8;
  localparam int DIFF_W       = 17;
  localparam int NUM_W        = 24;
  localparam int FRAC_W       = 7;
  localparam int TEMP_W       = 15;
  localparam int LEN_A        = 161;
  localparam int LEN_B        = 151;
  localparam int OFS_A        = 40;
  localparam int OFS_B        = 30;
  localparam int DEG_SCALE    = 100;

  localparam logic signed [TEMP_W-1:0] COLD_A = TEMP_W'(-(OFS_A * DEG_SCALE));
  localparam logic signed [TEMP_W-1:0] COLD_B = TEMP_W'(-(OFS_B * DEG_SCALE));
  localparam logic signed [TEMP_W-1:0] HOT_A  = TEMP_W'((LEN_A - 1 - OFS_A) * DEG_SCALE);
  localparam logic signed [TEMP_W-1:0] HOT_B  = TEMP_W'((LEN_B - 1 - OFS_B) * DEG_SCALE);
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = COLD_A;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = HOT_A;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_BELOW = 2'd2,
    ST_ABOVE = 2'd3
  } ntc_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_MVCHK,
    S_DIV1,
    S_SRCH,
    S_PREP,
    S_DIV2,
    S_OUT
  } ntc_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } ntc_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } ntc_div_rsp_t;

  typedef struct packed {
    logic                     valid;
    logic signed [TEMP_W-1:0] temperature;
    ntc_status_t              status;
  } ntc_result_t;

  localparam logic [ENT_W-1:0] TAB_A [LEN_A] = '{
    21'd1076457, 21'd1015739, 21'd958854, 21'd905535, 21'd855537, 21'd808631,
    21'd764607, 21'd723269, 21'd684436, 21'd647942,
    21'd613631, 21'd581358, 21'd550991, 21'd522404, 21'd495483, 21'd470121,
    21'd446217, 21'd423680, 21'd402422, 21'd382364,
    21'd363430, 21'd345551, 21'd328662, 21'd312703, 21'd297616, 21'd283349,
    21'd269853, 21'd257081, 21'd244990, 21'd233541,
    21'd222695, 21'd212417, 21'd202675, 21'd193437, 21'd184674, 21'd176360,
    21'd168469, 21'd160976, 21'd153860, 21'd147100,
    21'd140675, 21'd134568, 21'd128761, 21'd123237, 21'd117982, 21'd112980,
    21'd108219, 21'd103684, 21'd99365, 21'd95250,
    21'd91328, 21'd87589, 21'd84024, 21'd80623, 21'd77379, 21'd74282,
    21'd71326, 21'd68504, 21'd65809, 21'd63234,
    21'd60773, 21'd58422, 21'd56173, 21'd54024, 21'd51967, 21'd50000,
    21'd48117, 21'd46316, 21'd44590, 21'd42939,
    21'd41356, 21'd39840, 21'd38388, 21'd36996, 21'd35661, 21'd34381,
    21'd33154, 21'd31977, 21'd30847, 21'd29763,
    21'd28722, 21'd27723, 21'd26763, 21'd25842, 21'd24957, 21'd24106,
    21'd23288, 21'd22503, 21'd21747, 21'd21021,
    21'd20322, 21'd19650, 21'd19003, 21'd18381, 21'd17782, 21'd17205,
    21'd16650, 21'd16115, 21'd15600, 21'd15104,
    21'd14626, 21'd14165, 21'd13721, 21'd13293, 21'd12880, 21'd12482,
    21'd12098, 21'd11727, 21'd11370, 21'd11025,
    21'd10692, 21'd10371, 21'd10061, 21'd9761, 21'd9472, 21'd9193,
    21'd8923, 21'd8662, 21'd8410, 21'd8166,
    21'd7931, 21'd7703, 21'd7483, 21'd7270, 21'd7064, 21'd6865,
    21'd6672, 21'd6486, 21'd6305, 21'd6131,
    21'd5961, 21'd5798, 21'd5639, 21'd5486, 21'd5337, 21'd5193,
    21'd5053, 21'd4918, 21'd4787, 21'd4660,
    21'd4537, 21'd4418, 21'd4302, 21'd4190, 21'd4081, 21'd3976,
    21'd3873, 21'd3774, 21'd3677, 21'd3584,
    21'd3493, 21'd3405, 21'd3320, 21'd3237, 21'd3156, 21'd3078,
    21'd3002, 21'd2928, 21'd2856, 21'd2786,
    21'd2719
  };

  localparam logic [ENT_W-1:0] TAB_B [LEN_B] = '{
    21'd1792666, 21'd1684053, 21'd1582726, 21'd1488151, 21'd1399837, 21'd1317332,
    21'd1240216, 21'd1168107, 21'd1100648, 21'd1037512,
    21'd978396, 21'd923020, 21'd871124, 21'd822471, 21'd776837, 21'd734018,
    21'd693823, 21'd656077, 21'd620616, 21'd587288,
    21'd555953, 21'd526480, 21'd498747, 21'd472643, 21'd448062, 21'd424906,
    21'd403086, 21'd382516, 21'd363117, 21'd344817,
    21'd327547, 21'd311243, 21'd295847, 21'd281301, 21'd267556, 21'd254562,
    21'd242274, 21'd230650, 21'd219650, 21'd209239,
    21'd199380, 21'd190041, 21'd181193, 21'd172807, 21'd164857, 21'd157317,
    21'd150164, 21'd143376, 21'd136933, 21'd130816,
    21'd125005, 21'd119485, 21'd114239, 21'd109252, 21'd104510, 21'd100000,
    21'd95709, 21'd91626, 21'd87738, 21'd84037,
    21'd80512, 21'd77154, 21'd73953, 21'd70903, 21'd67995, 21'd65221,
    21'd62576, 21'd60051, 21'd57642, 21'd55342,
    21'd53146, 21'd51049, 21'd49045, 21'd47130, 21'd45300, 21'd43551,
    21'd41878, 21'd40278, 21'd38748, 21'd37283,
    21'd35882, 21'd34540, 21'd33255, 21'd32025, 21'd30846, 21'd29717,
    21'd28635, 21'd27597, 21'd26603, 21'd25649,
    21'd24734, 21'd23856, 21'd23014, 21'd22206, 21'd21431, 21'd20686,
    21'd19970, 21'd19283, 21'd18623, 21'd17989,
    21'd17380, 21'd16794, 21'd16231, 21'd15689, 21'd15168, 21'd14667,
    21'd14185, 21'd13722, 21'd13275, 21'd12845,
    21'd12431, 21'd12033, 21'd11649, 21'd11279, 21'd10923, 21'd10580,
    21'd10249, 21'd9930, 21'd9623, 21'd9326,
    21'd9040, 21'd8764, 21'd8498, 21'd8241, 21'd7994, 21'd7754,
    21'd7523, 21'd7300, 21'd7085, 21'd6877,
    21'd6676, 21'd6482, 21'd6295, 21'd6113, 21'd5938, 21'd5769,
    21'd5605, 21'd5447, 21'd5293, 21'd5145,
    21'd5002, 21'd4863, 21'd4729, 21'd4599, 21'd4474, 21'd4352,
    21'd4234, 21'd4120, 21'd4009, 21'd3902,
    21'd3799
  };

  function automatic logic [ENT_W-1:0] tab_entry(input logic sel, input logic [IDX_W-1:0] idx);
    logic [ENT_W-1:0] entry;
    entry = '0;
    if (sel) begin
      if (idx < IDX_W'(LEN_B)) entry = TAB_B[idx];
    end else begin
      if (idx < IDX_W'(LEN_A)) entry = TAB_A[idx];
    end
    return entry;
  endfunction

endpackage

// ===== design/ntc_div.sv =====
module ntc_div (
  input  logic                  clk,
  input  logic                  rst,
  input  ntc_pkg::ntc_div_req_t req,
  output ntc_pkg::ntc_div_rsp_t rsp
);
  import ntc_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     q;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W:0]       trial;
  logic                 ge;

  assign trial = {rem, q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        q    <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
        q   <= {q[DIV_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = q;

endmodule

// ===== design/ntc_seq.sv =====
module ntc_seq #(
  parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ADC_BITS-1:0]   in_code,
  input  logic                  in_done,
  input  logic                  table_sel,
  input  logic                  out_free,
  output ntc_pkg::ntc_result_t  result,
  output ntc_pkg::ntc_div_req_t div_req,
  input  ntc_pkg::ntc_div_rsp_t div_rsp
);
  import ntc_pkg::*;

  localparam int PROD_W = ADC_BITS + MV_W;

  ntc_state_t               state, state_next;
  logic [ADC_BITS-1:0]      code, code_next;
  logic                     conv_ok, conv_ok_next;
  logic                     sel, sel_next;
  logic [MV_W-1:0]          mv, mv_next;
  logic [DIV_W-1:0]         res, res_next;
  logic [IDX_W-1:0]         idx, idx_next;
  logic [ENT_W-1:0]         hi, hi_next;
  logic [ENT_W-1:0]         lo, lo_next;
  logic signed [TEMP_W-1:0] temp, temp_next;
  ntc_status_t              status, status_next;

  logic [PROD_W-1:0]        prod;
  logic [ENT_W-1:0]         entry;
  logic [IDX_W-1:0]         last_idx;
  logic signed [TEMP_W-1:0] cold;
  logic signed [TEMP_W-1:0] hot;
  logic [DIFF_W-1:0]        dnum;
  logic [NUM_W-1:0]         num;
  logic [ENT_W-1:0]         dden;
  logic signed [TEMP_W-1:0] deg;
  logic [FRAC_W-1:0]        frac;

  assign prod     = PROD_W'(code) * PROD_W'(MV_FULL);
  assign entry    = tab_entry(sel, idx);
  assign last_idx = sel ? IDX_W'(LEN_B - 1) : IDX_W'(LEN_A - 1);
  assign cold     = sel ? COLD_B : COLD_A;
  assign hot      = sel ? HOT_B : HOT_A;
  assign dnum     = DIFF_W'(res - DIV_W'(lo));
  assign num      = NUM_W'(dnum) * NUM_W'(DEG_SCALE);
  assign dden     = hi - lo;
  assign deg      = $signed(TEMP_W'(idx)) - (sel ? TEMP_W'(OFS_B) : TEMP_W'(OFS_A));
  assign frac     = div_rsp.quotient[FRAC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    code    <= code_next;
    conv_ok <= conv_ok_next;
    sel     <= sel_next;
    mv      <= mv_next;
    res     <= res_next;
    idx     <= idx_next;
    hi      <= hi_next;
    lo      <= lo_next;
    temp    <= temp_next;
    status  <= status_next;
  end

  always_comb begin
    state_next       = state;
    code_next        = code;
    conv_ok_next     = conv_ok;
    sel_next         = sel;
    mv_next          = mv;
    res_next         = res;
    idx_next         = idx;
    hi_next          = hi;
    lo_next          = lo;
    temp_next        = temp;
    status_next      = status;
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(DIVIDEND_R);
    div_req.divisor  = DIV_W'(mv);
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          code_next    = in_code;
          conv_ok_next = in_done;
          sel_next     = table_sel;
          state_next   = S_CONV;
        end
      end
      S_CONV: begin
        mv_next = MV_W'(prod >> ADC_BITS);
        if (!conv_ok) begin
          temp_next   = '0;
          status_next = ST_FAIL;
          state_next  = S_OUT;
        end else begin
          state_next = S_MVCHK;
        end
      end
      S_MVCHK: begin
        if (mv == '0) begin
          temp_next   = cold;
          status_next = ST_BELOW;
          state_next  = S_OUT;
        end else begin
          div_req.start = 1'b1;
          state_next    = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          res_next   = (div_rsp.quotient >= DIV_W'(RES_OFS)) ?
                       div_rsp.quotient - DIV_W'(RES_OFS) : '0;
          idx_next   = '0;
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        if (DIV_W'(entry) <= res) begin
          lo_next = entry;
          if (idx == '0) begin
            temp_next   = cold;
            status_next = (res == DIV_W'(entry)) ? ST_OK : ST_BELOW;
            state_next  = S_OUT;
          end else begin
            state_next = S_PREP;
          end
        end else if (idx == last_idx) begin
          temp_next   = hot;
          status_next = ST_ABOVE;
          state_next  = S_OUT;
        end else begin
          hi_next  = entry;
          idx_next = idx + 1'b1;
        end
      end
      S_PREP: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(num);
        div_req.divisor  = DIV_W'(dden);
        state_next       = S_DIV2;
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          temp_next   = TEMP_W'(deg * TEMP_W'(DEG_SCALE)) - $signed(TEMP_W'(frac));
          status_next = ST_OK;
          state_next  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign result.valid       = (state == S_OUT);
  assign result.temperature = temp;
  assign result.status      = status;

endmodule

// ===== design/ntc_adc_to_temperature_core.sv =====
// NTC thermistor converter: one ADC code of the divider in, one temperature in
// 0.01 degC plus a status out. An interpolated sample takes two passes of the shared
// one-bit-per-cycle restoring divider, one for the resistance and one for the
// interpolation fraction. Each pass runs its iterations and ends in the state that sees
// done. Add a table scan of one entry per cycle, at most the whole table, and
// the steps of accept, millivolt, start, setup and output. A resistance at or above the
// first entry ends the scan at the first entry, one below the last entry at the last.
// A timed-out conversion and a zero code skip the divider. s_tready is low while a
// sample is in work. The table select is sampled when a sample is taken.
module ntc_adc_to_temperature_core #(
  parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [((ADC_BITS+7)/8)*8-1:0]  s_tdata,  // adc_code
  input  logic                           s_tuser,  // conversion_done
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,  // temperature[14:0]
  output logic [1:0]                     m_tuser,  // status
  input  logic                           cfg_we,
  input  logic                           cfg_wdata  // sensor_table_select
);
  import ntc_pkg::*;

  logic                     table_sel;
  logic                     out_free;
  ntc_result_t              result;
  ntc_div_req_t             div_req;
  ntc_div_rsp_t             div_rsp;
  logic signed [TEMP_W-1:0] temperature;
  ntc_status_t              status;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_sel <= 1'b0;
    end else if (cfg_we) begin
      table_sel <= cfg_wdata;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  ntc_seq #(
    .ADC_BITS(ADC_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_code  (s_tdata[ADC_BITS-1:0]),
    .in_done  (s_tuser),
    .table_sel(table_sel),
    .out_free (out_free),
    .result   (result),
    .div_req  (div_req),
    .div_rsp  (div_rsp)
  );

  ntc_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= result.valid;
    end
    if (out_free && result.valid) begin
      temperature <= result.temperature;
      status      <= result.status;
    end
  end

  assign m_tdata = {1'b0, temperature};
  assign m_tuser = status;

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a sample is in work");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_FAIL |-> m_tdata == 16'd0)
    else $error("failed conversion with nonzero temperature");

  a_above_hot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_ABOVE |-> $signed(m_tdata[TEMP_W-1:0]) == HOT_A)
    else $error("above-table result not clamped to hot end");

  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_OK |->
      $signed(m_tdata[TEMP_W-1:0]) >= TEMP_MIN && $signed(m_tdata[TEMP_W-1:0]) <= TEMP_MAX)
    else $error("temperature out of table range");

endmodule
